// ===== rtl/msad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msad_pkg
// Shared codes, constants and types of the multi-symbol arithmetic decoder.
// ----------------------------------------------------------------------------
package msad_pkg;

	localparam logic [2:0] MODE_WRITE_BYTE = 3'd0;
	localparam logic [2:0] MODE_START      = 3'd1;
	localparam logic [2:0] MODE_WRITE_CDF  = 3'd2;
	localparam logic [2:0] MODE_DECODE     = 3'd3;
	localparam logic [2:0] MODE_BOOL       = 3'd4;
	localparam logic [2:0] MODE_READ_CDF   = 3'd5;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_SYMBOL = 2'd1;
	localparam logic [1:0] KIND_WORD   = 2'd2;

	localparam logic CFG_DISABLE = 1'b0;
	localparam logic CFG_LENGTH  = 1'b1;

	localparam int PROB_SHIFT = 6;
	localparam logic [14:0] HALF_CDF = 15'h4000;
	localparam logic [15:0] RANGE_INIT = 16'h8000;
	localparam logic signed [15:0] COUNT_INIT = -16'sd15;
	localparam logic signed [15:0] PAST_END_COUNT = 16'sh4000;
	localparam logic [14:0] CNT_LIMIT = 15'd32;

	typedef logic [14:0] cdf_word_t;

	typedef struct packed {
		logic [3:0] sym;
		logic [4:0] nsyms;
	} adapt_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/msad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msad_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module msad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                      wdata,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/msad_cdf_adapt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msad_cdf_adapt
// Adapts one context row of inverse CDF words toward the decoded symbol and
// advances the row's adaptation counter.
// ----------------------------------------------------------------------------
module msad_cdf_adapt #(
	parameter int MAX_SYMBOLS = 16
) (
	input  msad_pkg::adapt_ctrl_t                   ctrl,
	input  msad_pkg::cdf_word_t [MAX_SYMBOLS:0]     row_in,
	output msad_pkg::cdf_word_t [MAX_SYMBOLS:0]     row_out
);
	import msad_pkg::*;

	localparam int NW = MAX_SYMBOLS + 1;

	always_comb begin
		logic [14:0] cnt;
		logic [2:0]  rate;
		logic [15:0] up;
		cnt = '0;
		for (int i = 0; i < NW; i++) begin
			if (5'(i) == ctrl.nsyms) begin
				cnt = row_in[i];
			end
		end
		rate = 3'd3 + 3'(cnt > 15) + 3'(cnt > 31) + ((ctrl.nsyms >= 5'd4) ? 3'd2 : 3'd1);
		row_out = row_in;
		for (int i = 0; i < NW; i++) begin
			up = 16'h8000 - {1'b0, row_in[i]};
			if (5'(i + 1) < ctrl.nsyms) begin
				if (5'(i) >= {1'b0, ctrl.sym}) begin
					row_out[i] = row_in[i] - (row_in[i] >> rate);
				end else begin
					row_out[i] = 15'(({1'b0, row_in[i]} + (up >> rate)));
				end
			end
			if (5'(i) == ctrl.nsyms && cnt < CNT_LIMIT) begin
				row_out[i] = cnt + 15'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/multi_symbol_arithmetic_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_symbol_arithmetic_decoder_unit
// Multi-symbol range decoder with adaptive inverse CDFs held in a row memory.
// ----------------------------------------------------------------------------
// One item is in work at a time. Byte writes and unused modes go straight to the
// reply. A start runs a refill check, then a data step and a further check per
// refilled byte. A CDF write or read runs context reduction, row read and reply.
// A decoded symbol runs those two, the symbol search over candidates up to the
// decoded one, adaptation write-back (only when adapting), subtraction and
// normalisation, a refill when one is due, and the reply. A bool item skips the
// four context and row-read steps. The serial symbol search, one multiply per
// candidate, and the single-port CDF row memory set this step sequence. Both
// memories come up undefined and need no clearing pass.
module multi_symbol_arithmetic_decoder_unit #(
	parameter int BUFFER_BYTES = 4096,
	parameter int NUM_CONTEXTS = 1024,
	parameter int MAX_SYMBOLS  = 16,
	parameter int WINDOW_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  mode,
	input  wire logic [11:0] byte_address,
	input  wire logic [7:0]  byte_value,
	input  wire logic [9:0]  context_req,
	input  wire logic [4:0]  entry,
	input  wire logic [14:0] cdf_value,
	input  wire logic [4:0]  symbol_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [3:0]       symbol,
	output logic [14:0]      cdf_word
);
	import msad_pkg::*;

	localparam int NW  = MAX_SYMBOLS + 1;
	localparam int IW  = $clog2(NW);
	localparam int CAW = NUM_CONTEXTS > 1 ? $clog2(NUM_CONTEXTS) : 1;
	localparam int BAW = $clog2(BUFFER_BYTES);
	localparam int SW  = $clog2(WINDOW_BITS);
	localparam int WB  = WINDOW_BITS;
	localparam logic [20:0] CTX_RECIP = 21'((1 << 20) / NUM_CONTEXTS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CTX1   = 4'd1;
	localparam logic [3:0] S_CTX2   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_ROW    = 4'd4;
	localparam logic [3:0] S_SEARCH = 4'd5;
	localparam logic [3:0] S_ADAPT  = 4'd6;
	localparam logic [3:0] S_SUB    = 4'd7;
	localparam logic [3:0] S_NORM   = 4'd8;
	localparam logic [3:0] S_RF_CHK = 4'd9;
	localparam logic [3:0] S_RF_DAT = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0]  state_q;
	logic        disable_q;
	logic [12:0] dl_q;
	logic [WB-1:0] window_q;
	logic [15:0] range_q;
	logic signed [15:0] bc_q;
	logic [12:0] rp_q;
	logic        out_valid_q;

	logic [2:0]  mode_q;
	logic [4:0]  entry_q;
	logic [14:0] cdf_value_q;
	logic [9:0]  ctx_raw_q;
	logic [9:0]  quot_q;
	logic [CAW-1:0] ctx_q;
	logic [4:0]  nsyms_q;
	logic        bool_q;
	logic [1:0]  kind_q;
	logic [3:0]  sym_q;
	logic [14:0] word_q;
	logic [IW-1:0] k_q;
	logic [16:0] prev_q;
	logic [16:0] u_q;
	logic [16:0] v_q;
	logic [15:0] r_q;
	cdf_word_t [NW-1:0] row_q;
	logic [1:0]  res_kind_q;
	logic [3:0]  res_sym_q;
	logic [14:0] res_word_q;

	logic        accept;
	logic        tile_we;
	logic [BAW-1:0] tile_addr;
	logic [7:0]  tile_rdata;
	logic        cdf_we;
	cdf_word_t [NW-1:0] cdf_wdata;
	cdf_word_t [NW-1:0] cdf_rdata;
	cdf_word_t [NW-1:0] adapted;
	adapt_ctrl_t adapt_ctrl;

	logic [12:0] end_w;
	logic signed [16:0] shift_s;
	logic [4:0]  last_w;
	logic [4:0]  dist_w;
	logic [14:0] search_word;
	logic [16:0] prod_w;
	logic [16:0] v_w;
	logic [15:0] c_w;
	logic [31:0] rem_full;
	logic [31:0] rem_w;
	logic [3:0]  fl_w;
	logic [3:0]  d_w;
	logic signed [15:0] bc_new;
	logic [4:0]  nsyms_in;
	logic        entry_ok;
	logic        last_ready;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign result_kind = res_kind_q;
	assign symbol      = res_sym_q;
	assign cdf_word    = res_word_q;

	assign end_w   = (32'(dl_q) < 32'(BUFFER_BYTES)) ? dl_q : 13'(BUFFER_BYTES);
	assign shift_s = 17'(WB - 24) - {bc_q[15], bc_q};
	assign entry_ok = (32'(entry_q) <= 32'(MAX_SYMBOLS));

	assign tile_we   = accept && (mode == MODE_WRITE_BYTE)
		&& (32'(byte_address) < 32'(BUFFER_BYTES));
	assign tile_addr = (state_q == S_IDLE) ? BAW'(byte_address) : BAW'(rp_q);

	msad_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_tile_ram (
		.clk   (clk),
		.we    (tile_we),
		.addr  (tile_addr),
		.wdata (byte_value),
		.rdata (tile_rdata)
	);

	always_comb begin
		cdf_we    = 1'b0;
		cdf_wdata = adapted;
		if (state_q == S_ROW && mode_q == MODE_WRITE_CDF && entry_ok) begin
			cdf_we = 1'b1;
			cdf_wdata = cdf_rdata;
			cdf_wdata[entry_q[IW-1:0]] = cdf_value_q;
		end else if (state_q == S_ADAPT) begin
			cdf_we = 1'b1;
		end
	end

	msad_ram #(.WIDTH(NW * 15), .DEPTH(NUM_CONTEXTS)) u_cdf_ram (
		.clk   (clk),
		.we    (cdf_we),
		.addr  (ctx_q),
		.wdata (cdf_wdata),
		.rdata (cdf_rdata)
	);

	assign adapt_ctrl.sym   = sym_q;
	assign adapt_ctrl.nsyms = nsyms_q;

	msad_cdf_adapt #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_adapt (
		.ctrl    (adapt_ctrl),
		.row_in  (row_q),
		.row_out (adapted)
	);

	// symbol search datapath
	assign last_w = nsyms_q - 5'd1;
	assign dist_w = last_w - 5'(k_q);
	assign search_word = bool_q ? ((k_q == '0) ? HALF_CDF : 15'd0) : row_q[k_q];
	assign prod_w = 17'(range_q[15:8] * search_word[14:PROB_SHIFT]);
	assign last_ready = (5'(k_q) == last_w);
	assign v_w = last_ready ? 17'd0 : (17'(prod_w[16:1]) + {10'd0, dist_w, 2'd0});
	assign c_w = window_q[WB-1 -: 16];

	assign rem_full = 32'(ctx_raw_q) - 32'(quot_q) * 32'(NUM_CONTEXTS);
	assign rem_w = (rem_full >= 32'(NUM_CONTEXTS)) ? rem_full - 32'(NUM_CONTEXTS) : rem_full;

	always_comb begin
		fl_w = '0;
		for (int i = 1; i < 16; i++) begin
			if (r_q[i]) begin
				fl_w = 4'(i);
			end
		end
	end
	assign d_w    = 4'd15 - fl_w;
	assign bc_new = bc_q - 16'(d_w);

	assign nsyms_in = (symbol_count < 5'd2) ? 5'd2
		: ((32'(symbol_count) > 32'(MAX_SYMBOLS)) ? 5'(MAX_SYMBOLS) : symbol_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			disable_q   <= 1'b0;
			dl_q        <= '0;
			window_q    <= '0;
			range_q     <= RANGE_INIT;
			bc_q        <= COUNT_INIT;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DISABLE: disable_q <= cfg_data[0];
					CFG_LENGTH:  dl_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode) inside
							MODE_START: begin
								window_q <= {1'b0, {(WB - 1){1'b1}}};
								range_q  <= RANGE_INIT;
								bc_q     <= COUNT_INIT;
								rp_q     <= '0;
								state_q  <= S_RF_CHK;
							end
							MODE_WRITE_CDF, MODE_DECODE, MODE_READ_CDF: state_q <= S_CTX1;
							MODE_BOOL: state_q <= S_SEARCH;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CTX1: state_q <= S_CTX2;
				S_CTX2: state_q <= S_RD;
				S_RD:   state_q <= S_ROW;
				S_ROW: begin
					state_q <= (mode_q == MODE_DECODE) ? S_SEARCH : S_DONE;
				end
				S_SEARCH: begin
					if ({1'b0, c_w} >= v_w) begin
						state_q <= (mode_q == MODE_DECODE && !disable_q) ? S_ADAPT : S_SUB;
					end
				end
				S_ADAPT: state_q <= S_SUB;
				S_SUB: begin
					window_q <= window_q - (WB'(v_q[15:0]) << (WB - 16));
					state_q  <= S_NORM;
				end
				S_NORM: begin
					window_q <= ((window_q + WB'(1)) << d_w) - WB'(1);
					range_q  <= r_q << d_w;
					bc_q     <= bc_new;
					state_q  <= bc_new[15] ? S_RF_CHK : S_DONE;
				end
				S_RF_CHK: begin
					if (!shift_s[16] && rp_q < end_w) begin
						state_q <= S_RF_DAT;
					end else begin
						if (rp_q >= end_w) begin
							bc_q <= PAST_END_COUNT;
						end
						state_q <= S_DONE;
					end
				end
				S_RF_DAT: begin
					window_q <= window_q ^ (WB'(tile_rdata) << shift_s[SW-1:0]);
					rp_q     <= rp_q + 13'd1;
					bc_q     <= bc_q + 16'sd8;
					state_q  <= S_RF_CHK;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= mode;
			entry_q     <= entry;
			cdf_value_q <= cdf_value;
			ctx_raw_q   <= context_req;
			bool_q      <= (mode == MODE_BOOL);
			nsyms_q     <= (mode == MODE_BOOL) ? 5'd2 : nsyms_in;
			k_q         <= '0;
			prev_q      <= {1'b0, range_q};
			sym_q       <= '0;
			word_q      <= '0;
			if (mode == MODE_DECODE || mode == MODE_BOOL) begin
				kind_q <= KIND_SYMBOL;
			end else if (mode == MODE_READ_CDF) begin
				kind_q <= KIND_WORD;
			end else begin
				kind_q <= KIND_ACK;
			end
		end
		if (state_q == S_CTX1) begin
			quot_q <= 10'((31'(ctx_raw_q) * 31'(CTX_RECIP)) >> 20);
		end
		if (state_q == S_CTX2) begin
			ctx_q <= rem_w[CAW-1:0];
		end
		if (state_q == S_ROW) begin
			row_q <= cdf_rdata;
			if (mode_q == MODE_READ_CDF && entry_ok) begin
				word_q <= cdf_rdata[entry_q[IW-1:0]];
			end
		end
		if (state_q == S_SEARCH) begin
			if ({1'b0, c_w} >= v_w) begin
				u_q   <= prev_q;
				v_q   <= v_w;
				sym_q <= 4'(k_q);
			end else begin
				prev_q <= v_w;
				k_q    <= k_q + IW'(1);
			end
		end
		if (state_q == S_SUB) begin
			r_q <= 16'(u_q - v_q);
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			res_kind_q <= kind_q;
			res_sym_q  <= sym_q;
			res_word_q <= word_q;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in work");

	a_search_in_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (5'(k_q) <= last_w))
		else $error("symbol search ran past the last symbol");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result presented outside the completion step");
`endif

endmodule
`default_nettype wire
